FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the longest Collatz search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Types, constants and the microprogram of the longest Collatz search.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 65536;
  localparam int VAL_W   = 64;
  localparam int START_W = 16;
  localparam int CNT_W   = 10;
  localparam int UPC_W   = 4;
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] BEST_RST = CNT_W'(2);
  localparam logic [START_W-1:0] START_FIRST = START_W'(2);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_STEP,
    OP_READ,
    OP_WRITE,
    OP_NEXT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDLE,
    C_LIM_LOW,
    C_WALK_END,
    C_LAST
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic lim_low;
    logic walk_end;
    logic last;
  } flags_t;

  localparam logic [UPC_W-1:0] L_IDLE  = UPC_W'(0);
  localparam logic [UPC_W-1:0] L_CHECK = UPC_W'(1);
  localparam logic [UPC_W-1:0] L_INIT  = UPC_W'(2);
  localparam logic [UPC_W-1:0] L_TEST  = UPC_W'(3);
  localparam logic [UPC_W-1:0] L_STEP  = UPC_W'(4);
  localparam logic [UPC_W-1:0] L_READ  = UPC_W'(5);
  localparam logic [UPC_W-1:0] L_WRITE = UPC_W'(6);
  localparam logic [UPC_W-1:0] L_NEXT  = UPC_W'(7);
  localparam logic [UPC_W-1:0] L_EMIT  = UPC_W'(8);

  // A taken condition jumps to the target, otherwise the step counter advances.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
    unique case (addr)
      L_IDLE:  w = '{op: OP_LOAD,  cond: C_IDLE,     target: L_IDLE};
      L_CHECK: w = '{op: OP_NOP,   cond: C_LIM_LOW,  target: L_EMIT};
      L_INIT:  w = '{op: OP_INIT,  cond: C_NEVER,    target: L_IDLE};
      L_TEST:  w = '{op: OP_NOP,   cond: C_WALK_END, target: L_READ};
      L_STEP:  w = '{op: OP_STEP,  cond: C_ALWAYS,   target: L_TEST};
      L_READ:  w = '{op: OP_READ,  cond: C_NEVER,    target: L_IDLE};
      L_WRITE: w = '{op: OP_WRITE, cond: C_LAST,     target: L_EMIT};
      L_NEXT:  w = '{op: OP_NEXT,  cond: C_ALWAYS,   target: L_INIT};
      L_EMIT:  w = '{op: OP_EMIT,  cond: C_ALWAYS,   target: L_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: L_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/longest_collatz_search.sv
// ----------------------------------------------------------------------------
// longest_collatz_search
// Searches every start from two up to the requested limit for the longest
// Collatz trajectory, reusing the step counts of smaller starts.
// ----------------------------------------------------------------------------
//   Channel   Ports                              Handshake
//   request   in_upper_limit                     start high while busy low
//   result    out_best_start, out_best_length    out_strobe for one cycle
//
// Each start walks Collatz steps until the value reaches one or falls below
// the start, in a microprogram loop of a test step and an update step; the
// table entry of the value reached completes its count. A request adds the
// limit check and the result step, while the last start skips the advance.
// Reset idles the sequencer, sets best start and length to 2; table is not cleared.
// The result cannot be held off, and no request is taken while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module longest_collatz_search
  import lcs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [START_W-1:0] in_upper_limit,
  output logic                    out_strobe,
  output logic      [START_W-1:0] out_best_start,
  output logic      [CNT_W-1:0]   out_best_length
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam longint unsigned LIM_MAX = longint'(TABLE_DEPTH) - 1;

  uword_t             uword;
  flags_t             flags;
  logic [VAL_W-1:0]   val_r,       val_nxt;
  logic [START_W-1:0] cur_r,       cur_nxt;
  logic [START_W-1:0] limit_r,     limit_nxt;
  logic [CNT_W-1:0]   cnt_r,       cnt_nxt;
  logic [START_W-1:0] best_start_r, best_start_nxt;
  logic [CNT_W-1:0]   best_len_r,  best_len_nxt;
  logic [CNT_W:0]     sum;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   rd_data;
  logic               wr_en;
  logic               rd_en;

  lcs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uword (uword),
    .busy  (busy)
  );

  lcs_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cur_r)),
    .wr_data (total),
    .rd_en   (rd_en),
    .rd_addr (AW'(val_r)),
    .rd_data (rd_data)
  );

  assign flags.start    = start;
  assign flags.lim_low  = (limit_r < START_FIRST);
  assign flags.walk_end = (val_r == VAL_W'(1)) || (val_r < VAL_W'(cur_r));
  assign flags.last     = (cur_r == limit_r);

  assign wr_en = (uword.op == OP_WRITE);
  assign rd_en = (uword.op == OP_READ);

  // Entry one is never written; a walk that ends at one adds zero instead of its read.
  always_comb begin
    sum   = {1'b0, cnt_r} + ((val_r == VAL_W'(1)) ? '0 : {1'b0, rd_data});
    total = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  end

  always_comb begin
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    limit_nxt      = limit_r;
    cnt_nxt        = cnt_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    unique case (uword.op)
      OP_LOAD: begin
        if (64'(in_upper_limit) > LIM_MAX) begin
          limit_nxt = START_W'(LIM_MAX);
        end else begin
          limit_nxt = in_upper_limit;
        end
        cur_nxt        = START_FIRST;
        best_start_nxt = START_FIRST;
        best_len_nxt   = BEST_RST;
      end
      OP_INIT: begin
        val_nxt = VAL_W'(cur_r);
        cnt_nxt = '0;
      end
      OP_STEP: begin
        if (val_r[0]) begin
          val_nxt = {val_r[VAL_W-2:0], 1'b0} + val_r + VAL_W'(1);
        end else begin
          val_nxt = val_r >> 1;
        end
        cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
      end
      OP_WRITE: begin
        if (total > best_len_r) begin
          best_len_nxt   = total;
          best_start_nxt = cur_r;
        end
      end
      OP_NEXT: begin
        cur_nxt = cur_r + START_W'(1);
      end
      OP_NOP, OP_READ, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r        <= '0;
      cur_r        <= '0;
      cnt_r        <= '0;
      best_start_r <= START_FIRST;
      best_len_r   <= BEST_RST;
    end else begin
      val_r        <= val_nxt;
      cur_r        <= cur_nxt;
      cnt_r        <= cnt_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
  end

  assign out_strobe      = (uword.op == OP_EMIT);
  assign out_best_start  = best_start_r;
  assign out_best_length = best_len_r;

  `AST_IMPL(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `AST_NEXT(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `AST_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `AST_IMPL(a_best_floor, clk, rst_n, out_strobe, out_best_length >= BEST_RST)

endmodule

`default_nettype wire

FILE: rtl/lcs_seq.sv
// ----------------------------------------------------------------------------
// lcs_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_seq
  import lcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output uword_t      uword,
  output logic        busy
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             taken;

  assign uword = ucode(upc_r);
  assign busy  = (upc_r != L_IDLE);

  always_comb begin
    unique case (uword.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_IDLE:     taken = !flags.start;
      C_LIM_LOW:  taken = flags.lim_low;
      C_WALK_END: taken = flags.walk_end;
      C_LAST:     taken = flags.last;
      default:    taken = 1'b1;
    endcase
    upc_nxt = taken ? uword.target : upc_r + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= L_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcs_table.sv
// ----------------------------------------------------------------------------
// lcs_table
// Step count memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_table
  import lcs_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [CNT_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
